// File: rtl/tpbm_pkg.sv
// Shared types and constants of the transport stream PCR bitrate meter.
// No dependencies.
package tpbm_pkg;

   localparam int COUNT_BITS_DEF = 32;
   localparam int PCR_W          = 33;
   localparam int FIELD_W        = 32;
   localparam int QUO_W          = 64;

   // bits per packet times PCR ticks per second
   localparam int SCALE_W = 28;
   localparam logic [SCALE_W-1:0] BITRATE_SCALE = SCALE_W'(188 * 8 * 90000);

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_MUL_STEP,
      OP_DIV_STEP,
      OP_BR_STORE,
      OP_AVG_STORE,
      OP_OUT_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      kbit;   // scale bit for a multiply step
      logic      high;   // divide step produces a quotient bit at or above 2^64
   } dp_cmd_type;

   typedef struct packed {
      logic measure;     // word on the input closes a window with a positive delta
   } dp_status_type;

endpackage

// File: rtl/tpbm_dp.sv
// Datapath of the PCR bitrate meter: counters, window state, shift-add
// multiplier and shared restoring divider, result register. Uses tpbm_pkg.
module tpbm_dp #(
   parameter int COUNT_BITS = tpbm_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tpbm_pkg::dp_cmd_type         cmd,
   output tpbm_pkg::dp_status_type      status,
   input  logic                         req_pcr_present,
   input  logic [tpbm_pkg::PCR_W-1:0]   req_pcr_base,
   input  logic                         req_is_video,
   output logic [tpbm_pkg::FIELD_W-1:0] rsp_pcr_packets,
   output logic [tpbm_pkg::FIELD_W-1:0] rsp_video_packets,
   output logic                         rsp_new_measurement,
   output logic [tpbm_pkg::QUO_W-1:0]   rsp_last_bitrate,
   output logic [tpbm_pkg::QUO_W-1:0]   rsp_average_bitrate,
   output logic [tpbm_pkg::FIELD_W-1:0] rsp_measurement_count,
   output logic                         rsp_average_valid,
   output logic                         rsp_pair_error
);

   localparam int PCR_W   = tpbm_pkg::PCR_W;
   localparam int FIELD_W = tpbm_pkg::FIELD_W;
   localparam int QUO_W   = tpbm_pkg::QUO_W;
   localparam int PROD_W  = COUNT_BITS + tpbm_pkg::SCALE_W;
   localparam int DVD_W   = (PROD_W > QUO_W) ? PROD_W : QUO_W;
   localparam int DIV_W   = (COUNT_BITS > PCR_W) ? COUNT_BITS : PCR_W;

   logic [PCR_W-1:0]      start_ff, start_in;
   logic [COUNT_BITS-1:0] pkts_ff, pkts_in;
   logic [COUNT_BITS-1:0] pcr_tot_ff, pcr_tot_in;
   logic [COUNT_BITS-1:0] vid_tot_ff, vid_tot_in;
   logic [COUNT_BITS-1:0] meas_ff, meas_in;
   logic [QUO_W-1:0]      sum_ff, sum_in;
   logic [QUO_W-1:0]      latest_ff, latest_in;
   logic [QUO_W-1:0]      avg_ff, avg_in;

   logic [COUNT_BITS-1:0] mcand_ff, mcand_in;
   logic [DVD_W-1:0]      dvd_ff, dvd_in;
   logic [DIV_W-1:0]      divisor_ff, divisor_in;
   logic [DIV_W-1:0]      rem_ff, rem_in;
   logic [QUO_W-1:0]      q_ff, q_in;
   logic                  over_ff, over_in;
   logic                  fresh_ff, fresh_in;
   logic                  err_ff, err_in;

   logic [FIELD_W-1:0] out_pcr_ff, out_pcr_in;
   logic [FIELD_W-1:0] out_vid_ff, out_vid_in;
   logic               out_fresh_ff, out_fresh_in;
   logic [QUO_W-1:0]   out_latest_ff, out_latest_in;
   logic [QUO_W-1:0]   out_avg_ff, out_avg_in;
   logic [FIELD_W-1:0] out_meas_ff, out_meas_in;
   logic               out_avalid_ff, out_avalid_in;
   logic               out_err_ff, out_err_in;

   logic [FIELD_W-1:0] pcr_show, vid_show, meas_show;

   logic               pcr_valid;
   logic               pcr_later;
   logic [PCR_W-1:0]   delta;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     diff;
   logic               take;
   logic [QUO_W-1:0]   br;
   logic [QUO_W:0]     sum_wide;
   logic [QUO_W-1:0]   sum_sat;
   logic [COUNT_BITS-1:0] meas_inc;

   if (COUNT_BITS > FIELD_W) begin : g_clip
      assign pcr_show  = (|pcr_tot_ff[COUNT_BITS-1:FIELD_W]) ? '1 : pcr_tot_ff[FIELD_W-1:0];
      assign vid_show  = (|vid_tot_ff[COUNT_BITS-1:FIELD_W]) ? '1 : vid_tot_ff[FIELD_W-1:0];
      assign meas_show = (|meas_ff[COUNT_BITS-1:FIELD_W]) ? '1 : meas_ff[FIELD_W-1:0];
   end else begin : g_ext
      assign pcr_show  = FIELD_W'(pcr_tot_ff);
      assign vid_show  = FIELD_W'(vid_tot_ff);
      assign meas_show = FIELD_W'(meas_ff);
   end

   assign pcr_valid      = req_pcr_present && (|req_pcr_base);
   assign pcr_later      = req_pcr_base > start_ff;
   assign delta          = req_pcr_base - start_ff;
   assign status.measure = pcr_valid && (|start_ff) && pcr_later;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign take  = trial >= {1'b0, divisor_ff};

   assign br       = over_ff ? '1 : q_ff;
   assign sum_wide = {1'b0, sum_ff} + {1'b0, br};
   assign sum_sat  = sum_wide[QUO_W] ? '1 : sum_wide[QUO_W-1:0];
   assign meas_inc = (&meas_ff) ? meas_ff : meas_ff + COUNT_BITS'(1);

   always_comb begin
      start_in      = start_ff;
      pkts_in       = pkts_ff;
      pcr_tot_in    = pcr_tot_ff;
      vid_tot_in    = vid_tot_ff;
      meas_in       = meas_ff;
      sum_in        = sum_ff;
      latest_in     = latest_ff;
      avg_in        = avg_ff;
      mcand_in      = mcand_ff;
      dvd_in        = dvd_ff;
      divisor_in    = divisor_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      over_in       = over_ff;
      fresh_in      = fresh_ff;
      err_in        = err_ff;
      out_pcr_in    = out_pcr_ff;
      out_vid_in    = out_vid_ff;
      out_fresh_in  = out_fresh_ff;
      out_latest_in = out_latest_ff;
      out_avg_in    = out_avg_ff;
      out_meas_in   = out_meas_ff;
      out_avalid_in = out_avalid_ff;
      out_err_in    = out_err_ff;

      case (cmd.op)
         tpbm_pkg::OP_ACCEPT: begin
            if (req_is_video && !(&vid_tot_ff)) begin
               vid_tot_in = vid_tot_ff + COUNT_BITS'(1);
            end
            fresh_in   = 1'b0;
            err_in     = 1'b0;
            mcand_in   = pkts_ff;
            divisor_in = DIV_W'(delta);
            dvd_in     = '0;
            rem_in     = '0;
            q_in       = '0;
            over_in    = 1'b0;
            if (!pcr_valid) begin
               if (!(&pkts_ff)) begin
                  pkts_in = pkts_ff + COUNT_BITS'(1);
               end
            end else begin
               err_in   = (|start_ff) && !pcr_later;
               start_in = req_pcr_base;
               pkts_in  = '0;
               if (!(&pcr_tot_ff)) begin
                  pcr_tot_in = pcr_tot_ff + COUNT_BITS'(1);
               end
            end
         end
         tpbm_pkg::OP_MUL_STEP: begin
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0} + (cmd.kbit ? DVD_W'(mcand_ff) : '0);
         end
         tpbm_pkg::OP_DIV_STEP: begin
            dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
            rem_in  = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            q_in    = {q_ff[QUO_W-2:0], take};
            over_in = over_ff || (take && cmd.high);
         end
         tpbm_pkg::OP_BR_STORE: begin
            latest_in  = br;
            sum_in     = sum_sat;
            meas_in    = meas_inc;
            fresh_in   = 1'b1;
            dvd_in     = DVD_W'(sum_sat);
            divisor_in = DIV_W'(meas_inc);
            rem_in     = '0;
            q_in       = '0;
            over_in    = 1'b0;
         end
         tpbm_pkg::OP_AVG_STORE: begin
            avg_in = q_ff;
         end
         tpbm_pkg::OP_OUT_LOAD: begin
            out_pcr_in    = pcr_show;
            out_vid_in    = vid_show;
            out_fresh_in  = fresh_ff;
            out_latest_in = latest_ff;
            out_avg_in    = avg_ff;
            out_meas_in   = meas_show;
            out_avalid_in = |meas_ff;
            out_err_in    = err_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         pkts_ff    <= '0;
         pcr_tot_ff <= '0;
         vid_tot_ff <= '0;
         meas_ff    <= '0;
         sum_ff     <= '0;
         latest_ff  <= '0;
         avg_ff     <= '0;
      end else begin
         start_ff   <= start_in;
         pkts_ff    <= pkts_in;
         pcr_tot_ff <= pcr_tot_in;
         vid_tot_ff <= vid_tot_in;
         meas_ff    <= meas_in;
         sum_ff     <= sum_in;
         latest_ff  <= latest_in;
         avg_ff     <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff      <= mcand_in;
      dvd_ff        <= dvd_in;
      divisor_ff    <= divisor_in;
      rem_ff        <= rem_in;
      q_ff          <= q_in;
      over_ff       <= over_in;
      fresh_ff      <= fresh_in;
      err_ff        <= err_in;
      out_pcr_ff    <= out_pcr_in;
      out_vid_ff    <= out_vid_in;
      out_fresh_ff  <= out_fresh_in;
      out_latest_ff <= out_latest_in;
      out_avg_ff    <= out_avg_in;
      out_meas_ff   <= out_meas_in;
      out_avalid_ff <= out_avalid_in;
      out_err_ff    <= out_err_in;
   end

   assign rsp_pcr_packets       = out_pcr_ff;
   assign rsp_video_packets     = out_vid_ff;
   assign rsp_new_measurement   = out_fresh_ff;
   assign rsp_last_bitrate      = out_latest_ff;
   assign rsp_average_bitrate   = out_avg_ff;
   assign rsp_measurement_count = out_meas_ff;
   assign rsp_average_valid     = out_avalid_ff;
   assign rsp_pair_error        = out_err_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == tpbm_pkg::OP_DIV_STEP) |=> (rem_ff < divisor_ff))
      else $error("divider remainder not below divisor");

   a_store_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == tpbm_pkg::OP_BR_STORE) |=> (meas_ff != '0) && fresh_ff)
      else $error("stored bitrate without measurement count");

   a_load_clean: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == tpbm_pkg::OP_OUT_LOAD) |=> !(out_fresh_ff && out_err_ff))
      else $error("result word flags both a measurement and a pair error");
`endif

endmodule

// File: rtl/tpbm_ctrl.sv
// Sequencer of the PCR bitrate meter: input and result handshakes, step
// counter for the multiply and divide passes. Uses tpbm_pkg.
module tpbm_ctrl #(
   parameter int COUNT_BITS = tpbm_pkg::COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  tpbm_pkg::dp_status_type status,
   output tpbm_pkg::dp_cmd_type    cmd
);

   localparam int SCALE_W = tpbm_pkg::SCALE_W;
   localparam int QUO_W   = tpbm_pkg::QUO_W;
   localparam int PROD_W  = COUNT_BITS + SCALE_W;
   localparam int DVD_W   = (PROD_W > QUO_W) ? PROD_W : QUO_W;
   localparam int CNT_W   = $clog2(DVD_W + 1);
   localparam int KIDX_W  = $clog2(SCALE_W);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIV_BR,
      S_BR_STORE,
      S_DIV_AVG,
      S_AVG_STORE,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_fire;

   assign out_fire  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd.op       = tpbm_pkg::OP_NONE;
      cmd.kbit     = tpbm_pkg::BITRATE_SCALE[cnt_ff[KIDX_W-1:0]];
      cmd.high     = cnt_ff >= CNT_W'(QUO_W);
      rsp_valid_in = out_fire ? 1'b1 : (rsp_valid_ff && rsp_stall);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = tpbm_pkg::OP_ACCEPT;
               if (status.measure) begin
                  state_in = S_MUL;
                  cnt_in   = CNT_W'(SCALE_W - 1);
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_MUL: begin
            cmd.op = tpbm_pkg::OP_MUL_STEP;
            if (cnt_ff == '0) begin
               state_in = S_DIV_BR;
               cnt_in   = CNT_W'(DVD_W - 1);
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_DIV_BR: begin
            cmd.op = tpbm_pkg::OP_DIV_STEP;
            if (cnt_ff == '0) begin
               state_in = S_BR_STORE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_BR_STORE: begin
            cmd.op   = tpbm_pkg::OP_BR_STORE;
            state_in = S_DIV_AVG;
            cnt_in   = CNT_W'(DVD_W - 1);
         end
         S_DIV_AVG: begin
            cmd.op = tpbm_pkg::OP_DIV_STEP;
            if (cnt_ff == '0) begin
               state_in = S_AVG_STORE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_AVG_STORE: begin
            cmd.op   = tpbm_pkg::OP_AVG_STORE;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_fire) begin
               cmd.op   = tpbm_pkg::OP_OUT_LOAD;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == tpbm_pkg::OP_OUT_LOAD) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register loaded while a stalled word waits");

   a_measure_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && status.measure) |=>
         (state_ff == S_MUL && cnt_ff == CNT_W'(SCALE_W - 1)))
      else $error("closing PCR did not start the multiply pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled result word dropped");
`endif

endmodule

// File: rtl/ts_pcr_bitrate_meter.sv
// Top level of the transport stream PCR bitrate meter.
// Instantiates tpbm_ctrl and tpbm_dp; uses tpbm_pkg.
//
// One input word per transport packet; one result word per input word. A
// word that does not close a measurement window goes from acceptance through
// the done state to the result register. A nonzero PCR above the one that
// opened the window runs the bitrate pass: a shift-add multiply by
// 188*8*90000, then a restoring divide of that product by the PCR delta and a
// second divide of the running sum by the measurement count, one quotient bit
// per cycle over max(COUNT_BITS+28, 64) bits each, besides the accept, a store
// of the bitrate, a store of the average and a load of the result register; a
// stalled result in the result register holds off that load. One word is in
// work at a time; the result register lets the next word be taken while a
// finished result still waits.
module ts_pcr_bitrate_meter #(
   parameter int COUNT_BITS = tpbm_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_pcr_present,
   input  logic [tpbm_pkg::PCR_W-1:0]   req_pcr_base,
   input  logic                         req_is_video,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tpbm_pkg::FIELD_W-1:0] rsp_pcr_packets,
   output logic [tpbm_pkg::FIELD_W-1:0] rsp_video_packets,
   output logic                         rsp_new_measurement,
   output logic [tpbm_pkg::QUO_W-1:0]   rsp_last_bitrate,
   output logic [tpbm_pkg::QUO_W-1:0]   rsp_average_bitrate,
   output logic [tpbm_pkg::FIELD_W-1:0] rsp_measurement_count,
   output logic                         rsp_average_valid,
   output logic                         rsp_pair_error
);

   tpbm_pkg::dp_cmd_type    cmd;
   tpbm_pkg::dp_status_type status;

   tpbm_ctrl #(
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tpbm_dp #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_pcr_present       (req_pcr_present),
      .req_pcr_base          (req_pcr_base),
      .req_is_video          (req_is_video),
      .rsp_pcr_packets       (rsp_pcr_packets),
      .rsp_video_packets     (rsp_video_packets),
      .rsp_new_measurement   (rsp_new_measurement),
      .rsp_last_bitrate      (rsp_last_bitrate),
      .rsp_average_bitrate   (rsp_average_bitrate),
      .rsp_measurement_count (rsp_measurement_count),
      .rsp_average_valid     (rsp_average_valid),
      .rsp_pair_error        (rsp_pair_error)
   );

endmodule

// File: verif/tb.sv
// Self-checking testbench for ts_pcr_bitrate_meter: PCR pair windows, bitrate,
// running average, bad pairs and counters, checked word by word under random idling.
// Depends on rtl/tpbm_pkg.sv and rtl/ts_pcr_bitrate_meter.sv.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PCR_W       = tpbm_pkg::PCR_W;
   localparam int          FIELD_W     = tpbm_pkg::FIELD_W;
   localparam int          QUO_W       = tpbm_pkg::QUO_W;
   localparam int          CNT_W       = tpbm_pkg::COUNT_BITS_DEF;
   localparam logic [63:0] CNT_MAX     = (64'd1 << CNT_W) - 64'd1;
   localparam logic [63:0] RATE_SCALE  = 64'd1504 * 64'd90000;
   localparam int          IDLE_LIMIT  = 4000;
   localparam int          RANDOM_WORDS = 1700;

   typedef struct packed {
      logic [FIELD_W-1:0] pcr_packets;
      logic [FIELD_W-1:0] video_packets;
      logic               new_measurement;
      logic [QUO_W-1:0]   last_bitrate;
      logic [QUO_W-1:0]   average_bitrate;
      logic [FIELD_W-1:0] measurement_count;
      logic               average_valid;
      logic               pair_error;
   } report_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_HEAVY,
      STALL_LIGHT,
      STALL_PERIODIC
   } stall_mode_type;

   class tracker_type;
      logic [PCR_W-1:0] window_pcr;
      logic [63:0]      pkts_in_window;
      logic [63:0]      pcr_total;
      logic [63:0]      video_total;
      logic [63:0]      rate_sum;
      logic [63:0]      meas_total;
      logic [63:0]      latest_rate;
      report_type       expected[$];
      int               errors;
      int               reports;
      int               measures;
      int               bad_pairs;

      function new();
         window_pcr     = '0;
         pkts_in_window = '0;
         pcr_total      = '0;
         video_total    = '0;
         rate_sum       = '0;
         meas_total     = '0;
         latest_rate    = '0;
         errors         = 0;
         reports        = 0;
         measures       = 0;
         bad_pairs      = 0;
      endfunction

      function logic [63:0] bump(logic [63:0] v);
         return (v >= CNT_MAX) ? CNT_MAX : v + 64'd1;
      endfunction

      function logic [FIELD_W-1:0] clip32(logic [63:0] v);
         return (v > 64'hFFFF_FFFF) ? '1 : v[FIELD_W-1:0];
      endfunction

      function void absorb_packet(logic present, logic [PCR_W-1:0] base, logic video);
         report_type   r;
         logic [127:0] product;
         logic [127:0] quotient;
         logic [63:0]  rate;
         logic         fresh;
         logic         bad;
         fresh = 1'b0;
         bad   = 1'b0;
         if (video) video_total = bump(video_total);
         if (!present || base == '0) begin
            pkts_in_window = bump(pkts_in_window);
         end else begin
            if (window_pcr != '0) begin
               if (base > window_pcr) begin
                  product  = 128'(pkts_in_window) * 128'(RATE_SCALE);
                  quotient = product / 128'(base - window_pcr);
                  rate     = (quotient[127:64] != '0) ? '1 : quotient[63:0];
                  latest_rate = rate;
                  rate_sum    = (rate_sum > ~64'd0 - rate) ? '1 : rate_sum + rate;
                  meas_total  = bump(meas_total);
                  fresh = 1'b1;
                  measures++;
               end else begin
                  bad = 1'b1;
                  bad_pairs++;
               end
            end
            window_pcr     = base;
            pkts_in_window = '0;
            pcr_total      = bump(pcr_total);
         end
         r.pcr_packets       = clip32(pcr_total);
         r.video_packets     = clip32(video_total);
         r.new_measurement   = fresh;
         r.last_bitrate      = latest_rate;
         r.average_bitrate   = (meas_total != '0) ? rate_sum / meas_total : '0;
         r.measurement_count = clip32(meas_total);
         r.average_valid     = (meas_total != '0);
         r.pair_error        = bad;
         expected.insert(expected.size(), r);
      endfunction

      function void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
         if (want_v !== got_v) begin
            errors++;
            if (errors <= 10)
               $display("word %0d %s mismatch: expected %0h, got %0h",
                        reports, name, want_v, got_v);
         end
      endfunction

      function void compare_report(report_type got);
         report_type want;
         reports++;
         if (expected.size() == 0) begin
            errors++;
            if (errors <= 10) $display("word %0d arrived with nothing outstanding", reports);
            return;
         end
         want = expected.pop_front();
         check_field("pcr_packets", 64'(want.pcr_packets), 64'(got.pcr_packets));
         check_field("video_packets", 64'(want.video_packets), 64'(got.video_packets));
         check_field("new_measurement", 64'(want.new_measurement),
                     64'(got.new_measurement));
         check_field("last_bitrate", want.last_bitrate, got.last_bitrate);
         check_field("average_bitrate", want.average_bitrate, got.average_bitrate);
         check_field("measurement_count", 64'(want.measurement_count),
                     64'(got.measurement_count));
         check_field("average_valid", 64'(want.average_valid), 64'(got.average_valid));
         check_field("pair_error", 64'(want.pair_error), 64'(got.pair_error));
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_pcr_present = 1'b0;
   logic [PCR_W-1:0]   req_pcr_base = '0;
   logic               req_is_video = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [FIELD_W-1:0] rsp_pcr_packets;
   logic [FIELD_W-1:0] rsp_video_packets;
   logic               rsp_new_measurement;
   logic [QUO_W-1:0]   rsp_last_bitrate;
   logic [QUO_W-1:0]   rsp_average_bitrate;
   logic [FIELD_W-1:0] rsp_measurement_count;
   logic               rsp_average_valid;
   logic               rsp_pair_error;

   tracker_type        sb;
   int                 sent = 0;
   int                 burst_left = 0;
   int                 idle_cycles = 0;
   logic [PCR_W-1:0]   last_pcr = '0;
   stall_mode_type     stall_mode = STALL_NONE;
   int                 mode_left = 0;
   logic [7:0]         stall_tick = '0;

   ts_pcr_bitrate_meter #(.COUNT_BITS(CNT_W)) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_pcr_present       (req_pcr_present),
      .req_pcr_base          (req_pcr_base),
      .req_is_video          (req_is_video),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_pcr_packets       (rsp_pcr_packets),
      .rsp_video_packets     (rsp_video_packets),
      .rsp_new_measurement   (rsp_new_measurement),
      .rsp_last_bitrate      (rsp_last_bitrate),
      .rsp_average_bitrate   (rsp_average_bitrate),
      .rsp_measurement_count (rsp_measurement_count),
      .rsp_average_valid     (rsp_average_valid),
      .rsp_pair_error        (rsp_pair_error)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [PCR_W-1:0] rand33();
      return {1'($urandom_range(0, 1)), 32'($urandom())};
   endfunction

   task automatic hold_off(input int n);
      req_valid       <= 1'b0;
      req_pcr_present <= 1'($urandom_range(0, 1));
      req_pcr_base    <= rand33();
      req_is_video    <= 1'($urandom_range(0, 1));
      repeat (n) @(posedge clock);
   endtask

   task automatic send_packet(input logic present, input logic [PCR_W-1:0] base,
                              input logic video);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 12);
         hold_off($urandom_range(1, 20));
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_pcr_present <= present;
      req_pcr_base    <= base;
      req_is_video    <= video;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.absorb_packet(present, base, video);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic send_filler();
      if ($urandom_range(0, 4) == 0)
         send_packet(1'b1, '0, 1'($urandom_range(0, 1)));
      else
         send_packet(1'b0, rand33(), 1'($urandom_range(0, 1)));
   endtask

   task automatic random_traffic(input int count);
      int               target;
      int               last_drain;
      int               n;
      int               pick;
      logic [PCR_W-1:0] delta;
      logic [PCR_W:0]   wide;
      logic [PCR_W-1:0] next_pcr;
      target     = sent + count;
      last_drain = sent;
      while (sent < target) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 250) : $urandom_range(0, 12);
         repeat (n) send_filler();
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            case ($urandom_range(0, 3))
               0:       delta = PCR_W'($urandom_range(1, 16));
               1:       delta = PCR_W'($urandom_range(1, 100000));
               2:       delta = PCR_W'($urandom_range(100000, 50000000));
               default: delta = rand33();
            endcase
            wide     = {1'b0, last_pcr} + {1'b0, delta};
            next_pcr = wide[PCR_W-1:0];
         end else if (pick < 86) begin
            next_pcr = last_pcr;
         end else if (pick < 95) begin
            next_pcr = rand33();
         end else begin
            next_pcr = last_pcr - PCR_W'($urandom_range(1, 1000));
         end
         if (next_pcr == '0) next_pcr = PCR_W'(1);
         send_packet(1'b1, next_pcr, 1'($urandom_range(0, 1)));
         last_pcr = next_pcr;
         if (sent - last_drain >= 350) begin
            drain();
            last_drain = sent;
         end
      end
   endtask

   // receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= STALL_NONE;
         mode_left  <= 0;
         stall_tick <= '0;
      end else begin
         stall_tick <= stall_tick + 8'd1;
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(50, 600);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 1);
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
            default:     rsp_stall <= (stall_tick[3:0] < 4'd5);
         endcase
      end
   end

   always @(posedge clock) begin
      report_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.pcr_packets       = rsp_pcr_packets;
         got.video_packets     = rsp_video_packets;
         got.new_measurement   = rsp_new_measurement;
         got.last_bitrate      = rsp_last_bitrate;
         got.average_bitrate   = rsp_average_bitrate;
         got.measurement_count = rsp_measurement_count;
         got.average_valid     = rsp_average_valid;
         got.pair_error        = rsp_pair_error;
         sb.compare_report(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: zero PCR, absent PCR, first window, bad pairs, extreme deltas
      send_packet(1'b1, '0, 1'b1);
      send_packet(1'b0, '1, 1'b0);
      send_packet(1'b0, PCR_W'(123), 1'b1);
      send_packet(1'b1, PCR_W'(1000), 1'b0);
      send_packet(1'b0, '0, 1'b1);
      send_packet(1'b0, '1, 1'b1);
      send_packet(1'b1, PCR_W'(1000), 1'b0);
      send_packet(1'b1, PCR_W'(500), 1'b1);
      send_packet(1'b0, '0, 1'b1);
      send_packet(1'b1, PCR_W'(501), 1'b0);
      send_packet(1'b1, PCR_W'(502), 1'b1);
      send_packet(1'b1, '1, 1'b0);
      send_packet(1'b1, PCR_W'(1), 1'b1);
      repeat (3) send_packet(1'b0, '1, 1'b1);
      send_packet(1'b1, '1, 1'b1);
      send_packet(1'b1, '1, 1'b0);
      repeat (4) send_packet(1'b1, '0, 1'b0);
      send_packet(1'b1, PCR_W'(2), 1'b1);
      send_packet(1'b1, PCR_W'(3), 1'b1);
      last_pcr = PCR_W'(3);
      drain();

      random_traffic(RANDOM_WORDS);
      drain();
      repeat (200) @(posedge clock);

      $display("Sent %0d packets and checked %0d result words.", sent, sb.reports);
      $display("Windows closed with a bitrate: %0d; PCR pairs out of order: %0d.",
               sb.measures, sb.bad_pairs);
      if (sb.errors == 0 && sb.expected.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
